[design/ucrr_pkg.sv]
// ----------------------------------------------------------------------------
// ucrr_pkg: shared types and constants of the USB control request responder
// Request, descriptor, action and source codes plus the structs that carry
// an item, the device state and the length registers between modules.
// ----------------------------------------------------------------------------
package ucrr_pkg;

	// Event kinds on the command field.
	localparam logic [1:0] CMD_SETUP     = 2'd0;
	localparam logic [1:0] CMD_BUS_RESET = 2'd1;
	localparam logic [1:0] CMD_IN_DONE   = 2'd2;

	// Response actions.
	localparam logic [1:0] ACT_DATA   = 2'd0;
	localparam logic [1:0] ACT_STATUS = 2'd1;
	localparam logic [1:0] ACT_STALL  = 2'd2;
	localparam logic [1:0] ACT_NONE   = 2'd3;

	// Data sources.
	localparam logic [2:0] SRC_DEVICE  = 3'd0;
	localparam logic [2:0] SRC_CONFIG  = 3'd1;
	localparam logic [2:0] SRC_HID     = 3'd2;
	localparam logic [2:0] SRC_LANG    = 3'd3;
	localparam logic [2:0] SRC_MANUF   = 3'd4;
	localparam logic [2:0] SRC_PRODUCT = 3'd5;
	localparam logic [2:0] SRC_CFG_VAL = 3'd6;
	localparam logic [2:0] SRC_ZERO    = 3'd7;

	// Standard request codes.
	localparam logic [7:0] REQ_GET_STATUS        = 8'h00;
	localparam logic [7:0] REQ_SET_ADDRESS       = 8'h05;
	localparam logic [7:0] REQ_GET_DESCRIPTOR    = 8'h06;
	localparam logic [7:0] REQ_GET_CONFIGURATION = 8'h08;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;

	// Descriptor types.
	localparam logic [7:0] DT_DEVICE        = 8'h01;
	localparam logic [7:0] DT_CONFIGURATION = 8'h02;
	localparam logic [7:0] DT_STRING        = 8'h03;
	localparam logic [7:0] DT_HID_REPORT    = 8'h22;

	// Request type: type field mask and class value.
	localparam logic [7:0] RT_TYPE_MASK  = 8'h60;
	localparam logic [7:0] RT_TYPE_CLASS = 8'h20;

	// Fixed descriptor sizes.
	localparam logic [6:0] DEVICE_DESC_LEN = 7'd18;
	localparam logic [6:0] CONFIG_DESC_LEN = 7'd34;
	localparam logic [6:0] CFG_VAL_LEN     = 7'd1;
	localparam logic [6:0] STATUS_LEN      = 7'd2;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_HID_REPORT_LEN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LANG_STRING_LEN    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MANUF_STRING_LEN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRODUCT_STRING_LEN = 2'd3;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] request_value;
		logic [15:0] request_length;
	} req_t;

	typedef struct packed {
		logic [6:0] hid_report_len;
		logic [6:0] lang_string_len;
		logic [6:0] manuf_string_len;
		logic [6:0] product_string_len;
	} cfg_lens_t;

	typedef struct packed {
		logic       configured;
		logic [6:0] pending_addr;
		logic [6:0] current_addr;
	} dev_state_t;

	typedef struct packed {
		logic [1:0] action;
		logic [2:0] source;
		logic [6:0] send_length;
		logic       config_byte;
		logic       address_applied;
		logic [6:0] device_address;
		logic       configured;
		logic       enable_report_endpoint;
	} resp_t;

	// Smaller of the host's byte count and the source size.
	function automatic logic [6:0] cap_len(input logic [15:0] want, input logic [6:0] have);
		logic [6:0] r;
		if (want < {9'd0, have}) begin
			r = want[6:0];
		end else begin
			r = have;
		end
		return r;
	endfunction

endpackage

[design/ucrr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ucrr_cfg_regs: descriptor length registers
// Four 7-bit lengths written through a plain write port.
// ----------------------------------------------------------------------------
module ucrr_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ucrr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [6:0]                    cfg_data,
	output ucrr_pkg::cfg_lens_t           lens
);
	import ucrr_pkg::*;

	cfg_lens_t lens_q;

	// Register file with its reset sizes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lens_q.hid_report_len     <= 7'd63;
			lens_q.lang_string_len    <= 7'd4;
			lens_q.manuf_string_len   <= 7'd2;
			lens_q.product_string_len <= 7'd2;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HID_REPORT_LEN:     lens_q.hid_report_len     <= cfg_data;
				CFG_LANG_STRING_LEN:    lens_q.lang_string_len    <= cfg_data;
				CFG_MANUF_STRING_LEN:   lens_q.manuf_string_len   <= cfg_data;
				CFG_PRODUCT_STRING_LEN: lens_q.product_string_len <= cfg_data;
				default: ;
			endcase
		end
	end

	assign lens = lens_q;

endmodule

[design/ucrr_decode.sv]
// ----------------------------------------------------------------------------
// ucrr_decode: request decoder
// Maps one item and the current device state to a response and the
// device state that follows it.
// ----------------------------------------------------------------------------
module ucrr_decode (
	input  ucrr_pkg::req_t       req,
	input  ucrr_pkg::dev_state_t state,
	input  ucrr_pkg::cfg_lens_t  lens,
	output ucrr_pkg::resp_t      resp,
	output ucrr_pkg::dev_state_t next_state
);
	import ucrr_pkg::*;

	logic [7:0] dtype;
	logic [7:0] didx;
	logic       is_class;

	assign dtype    = req.request_value[15:8];
	assign didx     = req.request_value[7:0];
	assign is_class = (req.request_type & RT_TYPE_MASK) == RT_TYPE_CLASS;

	// Response and state update for each event kind.
	always_comb begin
		next_state                  = state;
		resp.action                 = ACT_NONE;
		resp.source                 = SRC_DEVICE;
		resp.send_length            = 7'd0;
		resp.config_byte            = 1'b0;
		resp.address_applied        = 1'b0;
		resp.enable_report_endpoint = 1'b0;
		case (req.command)
			CMD_SETUP: begin
				resp.action = ACT_STATUS;
				if (is_class) begin
					// Class requests: only the report descriptor sends data.
					if (req.request_code == REQ_GET_DESCRIPTOR && dtype == DT_HID_REPORT) begin
						resp.action      = ACT_DATA;
						resp.source      = SRC_HID;
						resp.send_length = cap_len(req.request_length, lens.hid_report_len);
					end
				end else begin
					case (req.request_code)
						REQ_GET_DESCRIPTOR: begin
							resp.action = ACT_DATA;
							case (dtype)
								DT_DEVICE: begin
									resp.source      = SRC_DEVICE;
									resp.send_length = cap_len(req.request_length,
										DEVICE_DESC_LEN);
								end
								DT_CONFIGURATION: begin
									resp.source      = SRC_CONFIG;
									resp.send_length = cap_len(req.request_length,
										CONFIG_DESC_LEN);
								end
								DT_STRING: begin
									if (didx == 8'd0) begin
										resp.source      = SRC_LANG;
										resp.send_length = cap_len(req.request_length,
											lens.lang_string_len);
									end else if (didx == 8'd1) begin
										resp.source      = SRC_MANUF;
										resp.send_length = cap_len(req.request_length,
											lens.manuf_string_len);
									end else begin
										resp.source      = SRC_PRODUCT;
										resp.send_length = cap_len(req.request_length,
											lens.product_string_len);
									end
								end
								DT_HID_REPORT: begin
									resp.source      = SRC_HID;
									resp.send_length = cap_len(req.request_length,
										lens.hid_report_len);
								end
								default: begin
									resp.action = ACT_STALL;
								end
							endcase
						end
						REQ_SET_ADDRESS: begin
							next_state.pending_addr = req.request_value[6:0];
						end
						REQ_SET_CONFIGURATION: begin
							next_state.configured       = 1'b1;
							resp.enable_report_endpoint = 1'b1;
						end
						REQ_GET_CONFIGURATION: begin
							resp.action      = ACT_DATA;
							resp.source      = SRC_CFG_VAL;
							resp.send_length = CFG_VAL_LEN;
							resp.config_byte = state.configured;
						end
						REQ_GET_STATUS: begin
							resp.action      = ACT_DATA;
							resp.source      = SRC_ZERO;
							resp.send_length = STATUS_LEN;
						end
						default: ;
					endcase
				end
			end
			CMD_BUS_RESET: begin
				next_state.configured = 1'b0;
			end
			CMD_IN_DONE: begin
				// A pending address becomes current after the status stage.
				if (state.pending_addr != 7'd0) begin
					next_state.current_addr = state.pending_addr;
					next_state.pending_addr = 7'd0;
					resp.address_applied    = 1'b1;
				end
			end
			default: ;
		endcase
		resp.device_address = next_state.current_addr;
		resp.configured     = next_state.configured;
	end

endmodule

[design/usb_control_request_responder_unit.sv]
// ----------------------------------------------------------------------------
// usb_control_request_responder_unit: endpoint-0 standard request handler
// Input register, decoder with device state, and an output register.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the input register, is decoded, and its
// response is registered in the output register. Throughput: one item per
// cycle unless out_ready stalls; the device state updates as an item leaves
// the input register, so consecutive items see each other's effects.
// Reset: arst_n clears the valid flags and device state and loads the
// descriptor length registers with their default sizes.
// ----------------------------------------------------------------------------
module usb_control_request_responder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ucrr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [6:0]                    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    command,
	input  logic [7:0]                    request_type,
	input  logic [7:0]                    request_code,
	input  logic [15:0]                   request_value,
	input  logic [15:0]                   request_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    action,
	output logic [2:0]                    source,
	output logic [6:0]                    send_length,
	output logic                          config_byte,
	output logic                          address_applied,
	output logic [6:0]                    device_address,
	output logic                          configured,
	output logic                          enable_report_endpoint
);
	import ucrr_pkg::*;

	cfg_lens_t  lens;
	req_t       req_s1;
	logic       valid_s1;
	dev_state_t state_q;
	dev_state_t next_state;
	resp_t      resp;
	resp_t      resp_s2;
	logic       valid_s2;
	logic       adv_s1;

	// Handshake: the item moves on whenever the output register is free or being read.
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	ucrr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.lens      (lens)
	);

	ucrr_decode u_decode (
		.req        (req_s1),
		.state      (state_q),
		.lens       (lens),
		.resp       (resp),
		.next_state (next_state)
	);

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.command        <= command;
			req_s1.request_type   <= request_type;
			req_s1.request_code   <= request_code;
			req_s1.request_value  <= request_value;
			req_s1.request_length <= request_length;
		end
	end

	// Device state commits as the item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= next_state;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			resp_s2 <= resp;
		end
	end

	assign out_valid              = valid_s2;
	assign action                 = resp_s2.action;
	assign source                 = resp_s2.source;
	assign send_length            = resp_s2.send_length;
	assign config_byte            = resp_s2.config_byte;
	assign address_applied        = resp_s2.address_applied;
	assign device_address         = resp_s2.device_address;
	assign configured             = resp_s2.configured;
	assign enable_report_endpoint = resp_s2.enable_report_endpoint;

	// An applied address is never zero.
	a_applied_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && address_applied |-> device_address != 7'd0)
		else $error("applied device address is zero");

	// Applying an address clears the pending one.
	a_pending_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && resp.address_applied |=> state_q.pending_addr == 7'd0)
		else $error("pending address kept after being applied");

	// Bringing up the report endpoint leaves the device configured.
	a_enable_configured: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && enable_report_endpoint |-> configured)
		else $error("report endpoint enabled while not configured");

	// Responses without data carry no source and no length.
	a_nodata_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action != ACT_DATA |-> source == SRC_DEVICE && send_length == 7'd0)
		else $error("non-data response carries data fields");

	// An empty input register always takes a new item.
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled with empty input register");

endmodule

[tb/usb_control_request_responder_unit_tb.sv]
// ----------------------------------------------------------------------------
// usb_control_request_responder_unit_tb: self-checking bench for the EP0 responder
// Drives setup, bus reset and IN-complete events through the input handshake
// under random idling, takes each expected response from the script or a local
// model of the device state and length registers, and compares each returned item.
// ----------------------------------------------------------------------------
module usb_control_request_responder_unit_tb;
	import ucrr_pkg::*;

	// Codes that the package does not name.
	localparam logic [1:0] CMD_IGNORED       = 2'd3;
	localparam logic [7:0] REQ_CLEAR_FEATURE = 8'h01;
	localparam logic [7:0] REQ_SET_IDLE      = 8'h0A;
	localparam logic [7:0] DT_INTERFACE      = 8'h04;
	localparam logic [7:0] STR_IDX_LANG      = 8'd0;
	localparam logic [7:0] STR_IDX_MANUF     = 8'd1;
	localparam logic [7:0] RT_STD_OUT        = 8'h00;
	localparam logic [7:0] RT_STD_IN         = 8'h80;
	localparam logic [7:0] RT_STD_IFACE_IN   = 8'h81;
	localparam logic [7:0] RT_CLASS_OUT      = 8'h21;
	localparam logic [7:0] RT_CLASS_IN       = 8'hA1;
	localparam logic [7:0] RT_CLASS_DEV      = 8'h20;
	localparam logic [7:0] RT_VENDOR         = 8'h40;
	localparam logic [7:0] RT_RESERVED       = 8'h60;
	localparam int         RANDOM_PER_PHASE  = 125;
	localparam int         DRAIN_GUARD       = 5000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [6:0]           cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [1:0]           command = '0;
	logic [7:0]           request_type = '0;
	logic [7:0]           request_code = '0;
	logic [15:0]          request_value = '0;
	logic [15:0]          request_length = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           action;
	logic [2:0]           source;
	logic [6:0]           send_length;
	logic                 config_byte;
	logic                 address_applied;
	logic [6:0]           device_address;
	logic                 configured;
	logic                 enable_report_endpoint;

	usb_control_request_responder_unit dut (.*);

	always #2 clk = ~clk;

	// Local copy of the device state and the descriptor length registers.
	cfg_lens_t  lens = '{hid_report_len: 7'd63, lang_string_len: 7'd4,
		manuf_string_len: 7'd2, product_string_len: 7'd2};
	logic       dev_cfgd = 1'b0;
	logic [6:0] addr_waiting = '0;
	logic [6:0] addr_now = '0;

	resp_t awaited_answers[$];
	int    fault_count = 0;
	int    reported = 0;
	int    events_sent = 0;
	int    answers_seen = 0;
	int    settings_used = 1;
	bit    steady = 1'b0;

	typedef struct {
		req_t  ev;
		bit    typed;
		resp_t want;
	} script_row_t;

	script_row_t script[$];

	// Bytes actually sent: the host's limit or the source size, whichever is less.
	function automatic logic [6:0] clip_len(input logic [15:0] want, input logic [6:0] limit);
		return (want < {9'd0, limit}) ? want[6:0] : limit;
	endfunction

	// Works out the response to one event and advances the device state.
	function automatic resp_t answer_event(input req_t ev);
		resp_t      r;
		logic [7:0] dtype;
		logic [7:0] didx;
		r = '0;
		r.action = ACT_NONE;
		dtype = ev.request_value[15:8];
		didx = ev.request_value[7:0];
		case (ev.command)
			CMD_SETUP: begin
				r.action = ACT_STATUS;
				if ((ev.request_type & RT_TYPE_MASK) == RT_TYPE_CLASS) begin
					// Class requests only ever send the report descriptor.
					if (ev.request_code == REQ_GET_DESCRIPTOR && dtype == DT_HID_REPORT) begin
						r.action = ACT_DATA;
						r.source = SRC_HID;
						r.send_length = clip_len(ev.request_length, lens.hid_report_len);
					end
				end else if (ev.request_code == REQ_GET_DESCRIPTOR) begin
					r.action = ACT_DATA;
					case (dtype)
						DT_DEVICE: begin
							r.source = SRC_DEVICE;
							r.send_length = clip_len(ev.request_length, DEVICE_DESC_LEN);
						end
						DT_CONFIGURATION: begin
							r.source = SRC_CONFIG;
							r.send_length = clip_len(ev.request_length, CONFIG_DESC_LEN);
						end
						DT_STRING: begin
							if (didx == STR_IDX_LANG) begin
								r.source = SRC_LANG;
								r.send_length = clip_len(ev.request_length, lens.lang_string_len);
							end else if (didx == STR_IDX_MANUF) begin
								r.source = SRC_MANUF;
								r.send_length = clip_len(ev.request_length, lens.manuf_string_len);
							end else begin
								r.source = SRC_PRODUCT;
								r.send_length = clip_len(ev.request_length,
									lens.product_string_len);
							end
						end
						DT_HID_REPORT: begin
							r.source = SRC_HID;
							r.send_length = clip_len(ev.request_length, lens.hid_report_len);
						end
						default: begin
							r.action = ACT_STALL;
						end
					endcase
				end else if (ev.request_code == REQ_SET_ADDRESS) begin
					addr_waiting = ev.request_value[6:0];
				end else if (ev.request_code == REQ_SET_CONFIGURATION) begin
					dev_cfgd = 1'b1;
					r.enable_report_endpoint = 1'b1;
				end else if (ev.request_code == REQ_GET_CONFIGURATION) begin
					r.action = ACT_DATA;
					r.source = SRC_CFG_VAL;
					r.send_length = CFG_VAL_LEN;
					r.config_byte = dev_cfgd;
				end else if (ev.request_code == REQ_GET_STATUS) begin
					r.action = ACT_DATA;
					r.source = SRC_ZERO;
					r.send_length = STATUS_LEN;
				end
			end
			CMD_BUS_RESET: begin
				dev_cfgd = 1'b0;
			end
			CMD_IN_DONE: begin
				// A pending address moves to current on the next IN completion.
				if (addr_waiting != '0) begin
					addr_now = addr_waiting;
					addr_waiting = '0;
					r.address_applied = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.device_address = addr_now;
		r.configured = dev_cfgd;
		return r;
	endfunction

	function automatic resp_t reply(input logic [1:0] act, input logic [2:0] src,
		input logic [6:0] len, input logic cbyte, input logic applied,
		input logic [6:0] addr, input logic cfgd, input logic ep);
		resp_t r;
		r = '{action: act, source: src, send_length: len, config_byte: cbyte,
			address_applied: applied, device_address: addr, configured: cfgd,
			enable_report_endpoint: ep};
		return r;
	endfunction

	function automatic void add_row(input logic [1:0] cmd, input logic [7:0] rt,
		input logic [7:0] rc, input logic [15:0] val, input logic [15:0] len,
		input bit typed, input resp_t want);
		script_row_t row;
		row.ev = '{command: cmd, request_type: rt, request_code: rc,
			request_value: val, request_length: len};
		row.typed = typed;
		row.want = want;
		script.push_back(row);
	endfunction

	function automatic int draw_wait();
		return steady ? 0 : $urandom_range(0, 5);
	endfunction

	// Mostly well-formed setup packets with random content, plus the other events.
	function automatic req_t random_event();
		req_t ev;
		int   pick;
		ev.command = CMD_SETUP;
		ev.request_type = 8'($urandom);
		ev.request_code = 8'($urandom);
		ev.request_value = 16'($urandom);
		ev.request_length = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			ev.command = CMD_BUS_RESET;
		end else if (pick < 24) begin
			ev.command = CMD_IN_DONE;
		end else if (pick < 28) begin
			ev.command = CMD_IGNORED;
		end else begin
			// Request type: standard most often, then class, vendor or reserved.
			case ($urandom_range(0, 5))
				0, 1, 2: ev.request_type[6:5] = 2'b00;
				3:       ev.request_type[6:5] = 2'b01;
				4:       ev.request_type[6:5] = 2'($urandom_range(2, 3));
				default: begin
				end
			endcase
			case ($urandom_range(0, 7))
				0: ev.request_code = REQ_GET_STATUS;
				1: ev.request_code = REQ_SET_ADDRESS;
				2, 3: ev.request_code = REQ_GET_DESCRIPTOR;
				4: ev.request_code = REQ_GET_CONFIGURATION;
				5: ev.request_code = REQ_SET_CONFIGURATION;
				6: ev.request_code = REQ_SET_IDLE;
				default: begin
				end
			endcase
			if (ev.request_code == REQ_GET_DESCRIPTOR) begin
				case ($urandom_range(0, 5))
					0: ev.request_value[15:8] = DT_DEVICE;
					1: ev.request_value[15:8] = DT_CONFIGURATION;
					2, 3: ev.request_value[15:8] = DT_STRING;
					4: ev.request_value[15:8] = DT_HID_REPORT;
					default: begin
					end
				endcase
				if ($urandom_range(0, 2) != 0)
					ev.request_value[7:0] = 8'($urandom_range(0, 2));
			end else if (ev.request_code == REQ_SET_ADDRESS && $urandom_range(0, 9) == 0) begin
				ev.request_value = '0;
			end
			case ($urandom_range(0, 4))
				0, 1: ev.request_length = 16'($urandom_range(0, 140));
				2: ev.request_length = 16'hFFFF;
				3: ev.request_length = '0;
				default: begin
				end
			endcase
		end
		return ev;
	endfunction

	// Offers one item after a random gap, then records the expected response.
	task automatic send_event(input req_t ev, input bit typed, input resp_t want);
		int    gap;
		resp_t predicted;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= ev.command;
		request_type <= ev.request_type;
		request_code <= ev.request_code;
		request_value <= ev.request_value;
		request_length <= ev.request_length;
		do @(negedge clk); while (in_ready !== 1'b1);
		@(posedge clk);
		predicted = answer_event(ev);
		awaited_answers.push_back(typed ? want : predicted);
		events_sent++;
	endtask

	// Writes all four length registers back to back while the block is idle.
	task automatic apply_lengths(input logic [6:0] hid, input logic [6:0] lang,
		input logic [6:0] manuf, input logic [6:0] product);
		logic [6:0] vals[4];
		vals = '{hid, lang, manuf, product};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		lens = '{hid_report_len: hid, lang_string_len: lang,
			manuf_string_len: manuf, product_string_len: product};
		settings_used++;
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		while (awaited_answers.size() != 0 && guard < DRAIN_GUARD) begin
			@(posedge clk);
			guard++;
		end
		repeat (4) @(posedge clk);
	endtask

	// Response side: random stalls, then compare each accepted item.
	initial begin : response_side
		int    stall;
		resp_t got;
		resp_t want;
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(negedge clk); while (out_valid !== 1'b1);
			got = '{action: action, source: source, send_length: send_length,
				config_byte: config_byte, address_applied: address_applied,
				device_address: device_address, configured: configured,
				enable_report_endpoint: enable_report_endpoint};
			answers_seen++;
			if (awaited_answers.size() == 0) begin
				fault_count++;
				if (reported < 10) begin
					reported++;
					$display("ERROR: response %0d arrived with no event waiting", answers_seen);
				end
			end else begin
				want = awaited_answers.pop_front();
				if (got !== want) begin
					fault_count++;
					if (reported < 10) begin
						reported++;
						$display("ERROR: response %0d (expected/actual): action %0d/%0d",
							answers_seen, want.action, got.action,
							" source %0d/%0d length %0d/%0d cfg byte %0d/%0d",
							want.source, got.source, want.send_length, got.send_length,
							want.config_byte, got.config_byte);
						$display("       applied %0d/%0d address %0d/%0d configured %0d/%0d",
							want.address_applied, got.address_applied,
							want.device_address, got.device_address,
							want.configured, got.configured,
							" report ep %0d/%0d", want.enable_report_endpoint,
							got.enable_report_endpoint);
					end
				end
			end
			@(posedge clk);
		end
	end

	// Event side: directed script under the reset lengths, then random phases.
	initial begin : event_side
		logic [6:0] phase_lens[4];
		int         count;
		count = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset lengths are hid 63, lang 4, manuf 2, product 2.
		add_row(CMD_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'hFFFF, 1,
			reply(ACT_DATA, SRC_DEVICE, 7'd18, 0, 0, 7'd0, 0, 0));
		add_row(CMD_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DT_CONFIGURATION, 8'h00},
			16'd9, 1, reply(ACT_DATA, SRC_CONFIG, 7'd9, 0, 0, 7'd0, 0, 0));
		add_row(CMD_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DT_CONFIGURATION, 8'h00},
			16'hFFFF, 1, reply(ACT_DATA, SRC_CONFIG, 7'd34, 0, 0, 7'd0, 0, 0));
		add_row(CMD_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DT_STRING, STR_IDX_LANG},
			16'h00FF, 1, reply(ACT_DATA, SRC_LANG, 7'd4, 0, 0, 7'd0, 0, 0));
		add_row(CMD_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DT_STRING, STR_IDX_MANUF},
			16'h00FF, 1, reply(ACT_DATA, SRC_MANUF, 7'd2, 0, 0, 7'd0, 0, 0));
		add_row(CMD_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DT_STRING, 8'hFF},
			16'h00FF, 1, reply(ACT_DATA, SRC_PRODUCT, 7'd2, 0, 0, 7'd0, 0, 0));
		add_row(CMD_SETUP, RT_STD_IFACE_IN, REQ_GET_DESCRIPTOR, {DT_HID_REPORT, 8'h00},
			16'hFFFF, 1, reply(ACT_DATA, SRC_HID, 7'd63, 0, 0, 7'd0, 0, 0));
		add_row(CMD_SETUP, RT_CLASS_IN, REQ_GET_DESCRIPTOR, {DT_HID_REPORT, 8'h00},
			16'h0000, 1, reply(ACT_DATA, SRC_HID, 7'd0, 0, 0, 7'd0, 0, 0));
		add_row(CMD_SETUP, RT_CLASS_OUT, REQ_SET_IDLE, 16'h0000, 16'h0000, 1,
			reply(ACT_STATUS, SRC_DEVICE, 7'd0, 0, 0, 7'd0, 0, 0));
		// A class request never changes the device state.
		add_row(CMD_SETUP, RT_CLASS_OUT, REQ_SET_CONFIGURATION, 16'h0001, 16'h0000, 1,
			reply(ACT_STATUS, SRC_DEVICE, 7'd0, 0, 0, 7'd0, 0, 0));
		add_row(CMD_SETUP, RT_STD_IN, REQ_GET_DESCRIPTOR, {DT_INTERFACE, 8'h00},
			16'h0020, 1, reply(ACT_STALL, SRC_DEVICE, 7'd0, 0, 0, 7'd0, 0, 0));
		add_row(CMD_SETUP, RT_STD_OUT, REQ_CLEAR_FEATURE, 16'hFFFF, 16'hFFFF, 1,
			reply(ACT_STATUS, SRC_DEVICE, 7'd0, 0, 0, 7'd0, 0, 0));
		add_row(CMD_SETUP, RT_STD_IN, REQ_GET_CONFIGURATION, 16'h0000, 16'h0001, 1,
			reply(ACT_DATA, SRC_CFG_VAL, 7'd1, 0, 0, 7'd0, 0, 0));
		add_row(CMD_SETUP, RT_STD_IN, REQ_GET_STATUS, 16'h0000, 16'h0002, 1,
			reply(ACT_DATA, SRC_ZERO, 7'd2, 0, 0, 7'd0, 0, 0));
		add_row(CMD_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 1,
			reply(ACT_NONE, SRC_DEVICE, 7'd0, 0, 0, 7'd0, 0, 0));
		// The new address only shows after the following IN completion.
		add_row(CMD_SETUP, RT_STD_OUT, REQ_SET_ADDRESS, 16'hFFFF, 16'h0000, 1,
			reply(ACT_STATUS, SRC_DEVICE, 7'd0, 0, 0, 7'd0, 0, 0));
		add_row(CMD_IN_DONE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1,
			reply(ACT_NONE, SRC_DEVICE, 7'd0, 0, 1, 7'h7F, 0, 0));
		add_row(CMD_SETUP, RT_STD_OUT, REQ_SET_CONFIGURATION, 16'hABCD, 16'h0000, 1,
			reply(ACT_STATUS, SRC_DEVICE, 7'd0, 0, 0, 7'h7F, 1, 1));
		add_row(CMD_SETUP, RT_STD_IN, REQ_GET_CONFIGURATION, 16'h0000, 16'h0001, 1,
			reply(ACT_DATA, SRC_CFG_VAL, 7'd1, 1, 0, 7'h7F, 1, 0));
		add_row(CMD_BUS_RESET, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1,
			reply(ACT_NONE, SRC_DEVICE, 7'd0, 0, 0, 7'h7F, 0, 0));
		add_row(CMD_IGNORED, 8'hFF, REQ_SET_CONFIGURATION, 16'hFFFF, 16'hFFFF, 1,
			reply(ACT_NONE, SRC_DEVICE, 7'd0, 0, 0, 7'h7F, 0, 0));
		add_row(CMD_SETUP, RT_CLASS_DEV, REQ_SET_ADDRESS, 16'h0011, 16'h0000, 0, '0);
		add_row(CMD_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 0, '0);
		add_row(CMD_SETUP, RT_VENDOR, REQ_GET_DESCRIPTOR, {DT_DEVICE, 8'h00}, 16'h0005, 0, '0);
		add_row(CMD_SETUP, RT_RESERVED, REQ_SET_ADDRESS, 16'h0123, 16'h0000, 0, '0);
		add_row(CMD_IN_DONE, 8'h00, 8'h00, 16'h0000, 16'h0000, 0, '0);

		foreach (script[i])
			send_event(script[i].ev, script[i].typed, script[i].want);
		in_valid <= 1'b0;
		drain();

		// Random phases, each under its own set of descriptor lengths.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: phase_lens = '{7'd0, 7'd0, 7'd0, 7'd0};
				1: phase_lens = '{7'd127, 7'd127, 7'd127, 7'd127};
				2: phase_lens = '{7'd127, 7'd0, 7'd127, 7'd0};
				default: begin
					foreach (phase_lens[k])
						phase_lens[k] = 7'($urandom_range(0, 127));
				end
			endcase
			apply_lengths(phase_lens[0], phase_lens[1], phase_lens[2], phase_lens[3]);
			for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
				if (count % 32 == 0)
					steady = ($urandom_range(0, 3) == 0);
				count++;
				send_event(random_event(), 0, '0);
			end
			in_valid <= 1'b0;
			drain();
		end

		fault_count += awaited_answers.size();
		$display("Coverage: %0d control events (%0d scripted) under %0d length settings.",
			events_sent, script.size(), settings_used);
		$display("Coverage: %0d responses compared against the predicted device behavior.",
			answers_seen);
		if (fault_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Hard stop far beyond the slowest correct run.
	initial begin : watchdog
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
design/ucrr_pkg.sv
design/ucrr_cfg_regs.sv
design/ucrr_decode.sv
design/usb_control_request_responder_unit.sv
tb/usb_control_request_responder_unit_tb.sv
